// File: src/tpsp_pkg.sv
package tpsp_pkg;

	localparam int unsigned MAX_RANKS = 64;

	localparam int unsigned NUM_W = 17;
	localparam int unsigned REM_W = 7;

	localparam int unsigned STEPS_MAX = 6;
	localparam int unsigned STEPS_S1  = 6;
	localparam int unsigned STEPS_S2  = 6;
	localparam int unsigned STEPS_S3  = 5;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_WORLD      = 4'd1,
		ST_RANK       = 4'd2,
		ST_SIZES      = 4'd3,
		ST_KV         = 4'd4,
		ST_HEADS      = 4'd5,
		ST_WO_TYPE    = 4'd6,
		ST_WO_ALIGN   = 4'd7,
		ST_DN_TYPE    = 4'd8,
		ST_FFN_MULT   = 4'd9,
		ST_FEW_BLOCKS = 4'd10
	} status_t;

	typedef enum logic [2:0] {
		CFG_QUERY_HEADS    = 3'd0,
		CFG_KV_HEADS       = 3'd1,
		CFG_HEAD_DIMENSION = 3'd2,
		CFG_FFN_SIZE       = 3'd3,
		CFG_WORLD_SIZE     = 3'd4,
		CFG_OUT_PROJ_TYPE  = 3'd5,
		CFG_DOWN_PROJ_TYPE = 3'd6
	} cfg_idx_t;

	localparam logic [4:0] QT_F32  = 5'd0;
	localparam logic [4:0] QT_F16  = 5'd1;
	localparam logic [4:0] QT_Q8   = 5'd8;
	localparam logic [4:0] QT_Q4K  = 5'd12;
	localparam logic [4:0] QT_Q6K  = 5'd14;

	typedef struct packed {
		logic       known;
		logic [3:0] shift;
	} quant_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] num;
	} div_lane_t;

	function automatic quant_t quant_lookup(logic [4:0] id);
		quant_t q;
		q = '{known: 1'b1, shift: 4'd0};
		case (id)
			QT_F32:  q.shift = 4'd0;
			QT_F16:  q.shift = 4'd0;
			QT_Q8:   q.shift = 4'd5;
			QT_Q4K:  q.shift = 4'd8;
			QT_Q6K:  q.shift = 4'd8;
			default: q = '{known: 1'b0, shift: 4'd0};
		endcase
		return q;
	endfunction

	// restoring division, quotient bits shift into the low end of num
	function automatic div_lane_t div_steps(div_lane_t lane, logic [REM_W-1:0] d,
			int unsigned n);
		div_lane_t      r;
		logic [REM_W:0] t;
		r = lane;
		for (int unsigned i = 0; i < STEPS_MAX; i++) begin
			if (i < n) begin
				t = {r.rem, r.num[NUM_W-1]};
				r.num = {r.num[NUM_W-2:0], 1'b0};
				if (t >= {1'b0, d}) begin
					r.rem = REM_W'(t - {1'b0, d});
					r.num[0] = 1'b1;
				end else begin
					r.rem = t[REM_W-1:0];
				end
			end
		end
		return r;
	endfunction

endpackage

// File: src/tensor_parallel_shard_planner.sv
// Shard planner for tensor-parallel inference.
// Configuration: write model sizes, world size and the two weight quant type
// ids over the cfg channel (cfg_index selects the register, cfg_data holds
// the value, cfg_ready is always high). Write only while no request is in
// flight; unknown indexes are dropped.
// Requests: drive rank_index with start high; busy stays low, so a request
// is taken at every clock edge where start is high.
// Results: a taken request passes stages s1 to s5; done pulses for one cycle
// with status and the query/kv head slices, query/kv row slices and the FFN
// row slice of that rank. On any failed check the slices are zero.
// Throughput is one request per cycle. The divider by world size has three
// stages of six, six and five quotient bits; one stage follows for the rank
// products and one for the row products and checks.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset restores query_heads, kv_heads, head_dimension, ffn_size and
// world_size to one and both type ids to zero, and empties the pipeline.
module tensor_parallel_shard_planner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [5:0]  rank_index,
	output logic        done,
	output logic [3:0]  status,
	output logic [8:0]  qhead_begin,
	output logic [8:0]  qhead_count,
	output logic [8:0]  kvhead_begin,
	output logic [8:0]  kvhead_count,
	output logic [18:0] qrow_begin,
	output logic [18:0] qrow_count,
	output logic [18:0] kvrow_begin,
	output logic [18:0] kvrow_count,
	output logic [16:0] ffnrow_begin,
	output logic [16:0] ffnrow_count
);

	logic [8:0]  query_heads_q;
	logic [8:0]  kv_heads_q;
	logic [9:0]  head_dimension_q;
	logic [16:0] ffn_size_q;
	logic [6:0]  world_size_q;
	logic [4:0]  out_proj_type_q;
	logic [4:0]  down_proj_type_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_heads_q    <= 9'd1;
			kv_heads_q       <= 9'd1;
			head_dimension_q <= 10'd1;
			ffn_size_q       <= 17'd1;
			world_size_q     <= 7'd1;
			out_proj_type_q  <= 5'd0;
			down_proj_type_q <= 5'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpsp_pkg::CFG_QUERY_HEADS:    query_heads_q    <= cfg_data[8:0];
				tpsp_pkg::CFG_KV_HEADS:       kv_heads_q       <= cfg_data[8:0];
				tpsp_pkg::CFG_HEAD_DIMENSION: head_dimension_q <= cfg_data[9:0];
				tpsp_pkg::CFG_FFN_SIZE:       ffn_size_q       <= cfg_data;
				tpsp_pkg::CFG_WORLD_SIZE:     world_size_q     <= cfg_data[6:0];
				tpsp_pkg::CFG_OUT_PROJ_TYPE:  out_proj_type_q  <= cfg_data[4:0];
				tpsp_pkg::CFG_DOWN_PROJ_TYPE: down_proj_type_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	tpsp_pkg::quant_t wo_qt;
	tpsp_pkg::quant_t dn_qt;
	logic [16:0]      ffn_blocks;

	assign wo_qt      = tpsp_pkg::quant_lookup(out_proj_type_q);
	assign dn_qt      = tpsp_pkg::quant_lookup(down_proj_type_q);
	assign ffn_blocks = ffn_size_q >> dn_qt.shift;

	// divider stages
	logic                   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [5:0]             rank_s1, rank_s2, rank_s3, rank_s4;
	tpsp_pkg::div_lane_t    qdiv_s1, kdiv_s1, fdiv_s1;
	tpsp_pkg::div_lane_t    qdiv_s2, kdiv_s2, fdiv_s2;
	tpsp_pkg::div_lane_t    qdiv_s3, kdiv_s3, fdiv_s3;
	tpsp_pkg::div_lane_t    qinit, kinit, finit;

	assign qinit = '{rem: '0, num: 17'(query_heads_q)};
	assign kinit = '{rem: '0, num: 17'(kv_heads_q)};
	assign finit = '{rem: '0, num: ffn_blocks};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		rank_s1 <= rank_index;
		qdiv_s1 <= tpsp_pkg::div_steps(qinit, world_size_q, tpsp_pkg::STEPS_S1);
		kdiv_s1 <= tpsp_pkg::div_steps(kinit, world_size_q, tpsp_pkg::STEPS_S1);
		fdiv_s1 <= tpsp_pkg::div_steps(finit, world_size_q, tpsp_pkg::STEPS_S1);

		rank_s2 <= rank_s1;
		qdiv_s2 <= tpsp_pkg::div_steps(qdiv_s1, world_size_q, tpsp_pkg::STEPS_S2);
		kdiv_s2 <= tpsp_pkg::div_steps(kdiv_s1, world_size_q, tpsp_pkg::STEPS_S2);
		fdiv_s2 <= tpsp_pkg::div_steps(fdiv_s1, world_size_q, tpsp_pkg::STEPS_S2);

		rank_s3 <= rank_s2;
		qdiv_s3 <= tpsp_pkg::div_steps(qdiv_s2, world_size_q, tpsp_pkg::STEPS_S3);
		kdiv_s3 <= tpsp_pkg::div_steps(kdiv_s2, world_size_q, tpsp_pkg::STEPS_S3);
		fdiv_s3 <= tpsp_pkg::div_steps(fdiv_s2, world_size_q, tpsp_pkg::STEPS_S3);
	end

	// rank products
	logic [14:0] qb_full, kb_full;
	logic [22:0] fb_full;
	logic [6:0]  lead;
	logic        gets_extra;

	assign qb_full    = 15'(rank_s3) * 15'(qdiv_s3.num[8:0]);
	assign kb_full    = 15'(rank_s3) * 15'(kdiv_s3.num[8:0]);
	assign fb_full    = 23'(rank_s3) * 23'(fdiv_s3.num);
	assign gets_extra = {1'b0, rank_s3} < fdiv_s3.rem;
	assign lead       = gets_extra ? {1'b0, rank_s3} : fdiv_s3.rem;

	logic [8:0]  qb_s4, qc_s4, kb_s4, kc_s4;
	logic [16:0] fb_s4, fc_s4;
	logic        qrem_s4, krem_s4;

	always_ff @(posedge clk) begin
		rank_s4 <= rank_s3;
		qb_s4   <= qb_full[8:0];
		qc_s4   <= qdiv_s3.num[8:0];
		kb_s4   <= kb_full[8:0];
		kc_s4   <= kdiv_s3.num[8:0];
		fb_s4   <= 17'(fb_full + 23'(lead));
		fc_s4   <= fdiv_s3.num + 17'(gets_extra);
		qrem_s4 <= |qdiv_s3.rem;
		krem_s4 <= |kdiv_s3.rem;
	end

	// row products and checks
	logic [18:0]       qrow_b, qrow_c, kvrow_b, kvrow_c, wo_mask;
	logic [16:0]       ffn_b, ffn_c, dn_mask;
	logic              world_bad, wo_misaligned;
	tpsp_pkg::status_t st;

	assign qrow_b  = 19'(qb_s4) * 19'(head_dimension_q);
	assign qrow_c  = 19'(qc_s4) * 19'(head_dimension_q);
	assign kvrow_b = 19'(kb_s4) * 19'(head_dimension_q);
	assign kvrow_c = 19'(kc_s4) * 19'(head_dimension_q);
	assign ffn_b   = fb_s4 << dn_qt.shift;
	assign ffn_c   = fc_s4 << dn_qt.shift;
	assign wo_mask = (19'd1 << wo_qt.shift) - 19'd1;
	assign dn_mask = (17'd1 << dn_qt.shift) - 17'd1;

	assign world_bad     = (world_size_q == 7'd0) || (32'(world_size_q) > tpsp_pkg::MAX_RANKS);
	assign wo_misaligned = (|(qrow_b & wo_mask)) || (|(qrow_c & wo_mask));

	always_comb begin
		if (world_bad) begin
			st = tpsp_pkg::ST_WORLD;
		end else if ({1'b0, rank_s4} >= world_size_q) begin
			st = tpsp_pkg::ST_RANK;
		end else if (query_heads_q == 9'd0 || kv_heads_q == 9'd0
				|| head_dimension_q == 10'd0 || ffn_size_q == 17'd0) begin
			st = tpsp_pkg::ST_SIZES;
		end else if (krem_s4) begin
			st = tpsp_pkg::ST_KV;
		end else if (qrem_s4) begin
			st = tpsp_pkg::ST_HEADS;
		end else if (!wo_qt.known) begin
			st = tpsp_pkg::ST_WO_TYPE;
		end else if (wo_misaligned) begin
			st = tpsp_pkg::ST_WO_ALIGN;
		end else if (!dn_qt.known) begin
			st = tpsp_pkg::ST_DN_TYPE;
		end else if (|(ffn_size_q & dn_mask)) begin
			st = tpsp_pkg::ST_FFN_MULT;
		end else if (ffn_blocks < 17'(world_size_q)) begin
			st = tpsp_pkg::ST_FEW_BLOCKS;
		end else begin
			st = tpsp_pkg::ST_OK;
		end
	end

	tpsp_pkg::status_t status_s5;
	logic [8:0]        qb_s5, qc_s5, kb_s5, kc_s5;
	logic [18:0]       qrow_b_s5, qrow_c_s5, kvrow_b_s5, kvrow_c_s5;
	logic [16:0]       ffn_b_s5, ffn_c_s5;
	logic              ok;

	assign ok = (st == tpsp_pkg::ST_OK);

	always_ff @(posedge clk) begin
		status_s5  <= st;
		qb_s5      <= ok ? qb_s4   : '0;
		qc_s5      <= ok ? qc_s4   : '0;
		kb_s5      <= ok ? kb_s4   : '0;
		kc_s5      <= ok ? kc_s4   : '0;
		qrow_b_s5  <= ok ? qrow_b  : '0;
		qrow_c_s5  <= ok ? qrow_c  : '0;
		kvrow_b_s5 <= ok ? kvrow_b : '0;
		kvrow_c_s5 <= ok ? kvrow_c : '0;
		ffn_b_s5   <= ok ? ffn_b   : '0;
		ffn_c_s5   <= ok ? ffn_c   : '0;
	end

	assign done         = valid_s5;
	assign status       = status_s5;
	assign qhead_begin  = qb_s5;
	assign qhead_count  = qc_s5;
	assign kvhead_begin = kb_s5;
	assign kvhead_count = kc_s5;
	assign qrow_begin   = qrow_b_s5;
	assign qrow_count   = qrow_c_s5;
	assign kvrow_begin  = kvrow_b_s5;
	assign kvrow_count  = kvrow_c_s5;
	assign ffnrow_begin = ffn_b_s5;
	assign ffnrow_count = ffn_c_s5;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("item accepted without a result five cycles later");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != tpsp_pkg::ST_OK) |->
		(qhead_count == '0 && kvhead_count == '0 && qrow_count == '0
		&& kvrow_count == '0 && ffnrow_count == '0 && qhead_begin == '0
		&& ffnrow_begin == '0))
		else $error("failed plan carries nonzero slices");

	a_ok_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == tpsp_pkg::ST_OK) |->
		(qhead_count != '0 && kvhead_count != '0 && ffnrow_count != '0))
		else $error("good plan with an empty slice");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= tpsp_pkg::ST_FEW_BLOCKS))
		else $error("status code out of range");

endmodule

// File: test/tpsp_shard_checker.sv
module tpsp_shard_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        start,
	input  logic        busy,
	input  logic [5:0]  rank_index,
	input  logic        done,
	input  logic [3:0]  status,
	input  logic [8:0]  qhead_begin,
	input  logic [8:0]  qhead_count,
	input  logic [8:0]  kvhead_begin,
	input  logic [8:0]  kvhead_count,
	input  logic [18:0] qrow_begin,
	input  logic [18:0] qrow_count,
	input  logic [18:0] kvrow_begin,
	input  logic [18:0] kvrow_count,
	input  logic [16:0] ffnrow_begin,
	input  logic [16:0] ffnrow_count,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned full_plans,
	output logic [10:0] status_seen
);

	typedef struct packed {
		tpsp_pkg::status_t status;
		logic [8:0]        qh_first;
		logic [8:0]        qh_cnt;
		logic [8:0]        kvh_first;
		logic [8:0]        kvh_cnt;
		logic [18:0]       qr_first;
		logic [18:0]       qr_cnt;
		logic [18:0]       kvr_first;
		logic [18:0]       kvr_cnt;
		logic [16:0]       fr_first;
		logic [16:0]       fr_cnt;
	} shard_t;

	logic [8:0]  qheads_cfg;
	logic [8:0]  kvheads_cfg;
	logic [9:0]  head_dim_cfg;
	logic [16:0] ffn_cfg;
	logic [6:0]  world_cfg;
	logic [4:0]  wo_type_cfg;
	logic [4:0]  down_type_cfg;

	shard_t plans_q[$];

	function automatic int unsigned quant_block_len(input logic [4:0] id);
		case (id)
			tpsp_pkg::QT_F32, tpsp_pkg::QT_F16: return 1;
			tpsp_pkg::QT_Q8:                    return 32;
			tpsp_pkg::QT_Q4K, tpsp_pkg::QT_Q6K: return 256;
			default:                            return 0;
		endcase
	endfunction

	// lower ranks take the remainder, one unit each
	function automatic void share_out(input int unsigned total, input int unsigned parts,
			input int unsigned idx, output int unsigned first, output int unsigned cnt);
		int unsigned base;
		int unsigned spare;
		base = total / parts;
		spare = total % parts;
		first = idx * base + ((idx < spare) ? idx : spare);
		cnt = base + ((idx < spare) ? 1 : 0);
	endfunction

	function automatic shard_t plan_shard(input logic [5:0] rank);
		shard_t      s;
		int unsigned w, qb, qc, kb, kc, fb, fc, bs, db;
		s = '0;
		w = world_cfg;
		bs = quant_block_len(wo_type_cfg);
		db = quant_block_len(down_type_cfg);
		if (w < 1 || w > tpsp_pkg::MAX_RANKS) begin
			s.status = tpsp_pkg::ST_WORLD;
		end else if (rank >= w) begin
			s.status = tpsp_pkg::ST_RANK;
		end else if (qheads_cfg == 0 || kvheads_cfg == 0 || head_dim_cfg == 0
				|| ffn_cfg == 0) begin
			s.status = tpsp_pkg::ST_SIZES;
		end else if (kvheads_cfg % w != 0) begin
			s.status = tpsp_pkg::ST_KV;
		end else if (qheads_cfg % w != 0) begin
			s.status = tpsp_pkg::ST_HEADS;
		end else begin
			share_out(qheads_cfg, w, rank, qb, qc);
			share_out(kvheads_cfg, w, rank, kb, kc);
			if (bs == 0) begin
				s.status = tpsp_pkg::ST_WO_TYPE;
			end else if ((qb * head_dim_cfg) % bs != 0 || (qc * head_dim_cfg) % bs != 0) begin
				s.status = tpsp_pkg::ST_WO_ALIGN;
			end else if (db == 0) begin
				s.status = tpsp_pkg::ST_DN_TYPE;
			end else if (ffn_cfg % db != 0) begin
				s.status = tpsp_pkg::ST_FFN_MULT;
			end else if (ffn_cfg / db < w) begin
				s.status = tpsp_pkg::ST_FEW_BLOCKS;
			end else begin
				share_out(ffn_cfg / db, w, rank, fb, fc);
				s.qh_first  = 9'(qb);
				s.qh_cnt    = 9'(qc);
				s.kvh_first = 9'(kb);
				s.kvh_cnt   = 9'(kc);
				s.qr_first  = 19'(qb * head_dim_cfg);
				s.qr_cnt    = 19'(qc * head_dim_cfg);
				s.kvr_first = 19'(kb * head_dim_cfg);
				s.kvr_cnt   = 19'(kc * head_dim_cfg);
				s.fr_first  = 17'(fb * db);
				s.fr_cnt    = 17'(fc * db);
			end
		end
		return s;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		shard_t want;
		if (!arst_n) begin
			qheads_cfg = 9'd1;
			kvheads_cfg = 9'd1;
			head_dim_cfg = 10'd1;
			ffn_cfg = 17'd1;
			world_cfg = 7'd1;
			wo_type_cfg = 5'd0;
			down_type_cfg = 5'd0;
			plans_q.delete();
			pending = 0;
			mismatches = 0;
			checked = 0;
			full_plans = 0;
			status_seen = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tpsp_pkg::CFG_QUERY_HEADS:    qheads_cfg = cfg_data[8:0];
					tpsp_pkg::CFG_KV_HEADS:       kvheads_cfg = cfg_data[8:0];
					tpsp_pkg::CFG_HEAD_DIMENSION: head_dim_cfg = cfg_data[9:0];
					tpsp_pkg::CFG_FFN_SIZE:       ffn_cfg = cfg_data;
					tpsp_pkg::CFG_WORLD_SIZE:     world_cfg = cfg_data[6:0];
					tpsp_pkg::CFG_OUT_PROJ_TYPE:  wo_type_cfg = cfg_data[4:0];
					tpsp_pkg::CFG_DOWN_PROJ_TYPE: down_type_cfg = cfg_data[4:0];
					default: ;
				endcase
			end
			if (done) begin
				if (plans_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request outstanding", $time);
				end else begin
					want = plans_q.pop_front();
					check_field("status", want.status, status);
					check_field("qhead_begin", want.qh_first, qhead_begin);
					check_field("qhead_count", want.qh_cnt, qhead_count);
					check_field("kvhead_begin", want.kvh_first, kvhead_begin);
					check_field("kvhead_count", want.kvh_cnt, kvhead_count);
					check_field("qrow_begin", want.qr_first, qrow_begin);
					check_field("qrow_count", want.qr_cnt, qrow_count);
					check_field("kvrow_begin", want.kvr_first, kvrow_begin);
					check_field("kvrow_count", want.kvr_cnt, kvrow_count);
					check_field("ffnrow_begin", want.fr_first, ffnrow_begin);
					check_field("ffnrow_count", want.fr_cnt, ffnrow_count);
					checked++;
					status_seen[want.status] = 1'b1;
					if (want.status == tpsp_pkg::ST_OK)
						full_plans++;
				end
			end
			if (start && !busy)
				plans_q.push_back(plan_shard(rank_index));
			pending = plans_q.size();
		end
	end

endmodule

// File: test/tb_tensor_parallel_shard_planner.sv
module tb_tensor_parallel_shard_planner;

	localparam int CLK_PERIOD = 8;
	localparam int unsigned RANDOM_ITEMS = 600;
	localparam logic [2:0] CFG_SPARE = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [16:0] cfg_data;
	logic        start;
	logic        busy;
	logic [5:0]  rank_index;
	logic        done;
	logic [3:0]  status;
	logic [8:0]  qhead_begin;
	logic [8:0]  qhead_count;
	logic [8:0]  kvhead_begin;
	logic [8:0]  kvhead_count;
	logic [18:0] qrow_begin;
	logic [18:0] qrow_count;
	logic [18:0] kvrow_begin;
	logic [18:0] kvrow_count;
	logic [16:0] ffnrow_begin;
	logic [16:0] ffnrow_count;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned checked;
	int unsigned full_plans;
	logic [10:0] status_seen;

	int unsigned items_sent;
	int unsigned settings_used;
	int unsigned burst_left;
	int unsigned cur_world;
	int unsigned item_goal;

	tensor_parallel_shard_planner i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.rank_index(rank_index),
		.done(done),
		.status(status),
		.qhead_begin(qhead_begin),
		.qhead_count(qhead_count),
		.kvhead_begin(kvhead_begin),
		.kvhead_count(kvhead_count),
		.qrow_begin(qrow_begin),
		.qrow_count(qrow_count),
		.kvrow_begin(kvrow_begin),
		.kvrow_count(kvrow_count),
		.ffnrow_begin(ffnrow_begin),
		.ffnrow_count(ffnrow_count)
	);

	tpsp_shard_checker i_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.rank_index(rank_index),
		.done(done),
		.status(status),
		.qhead_begin(qhead_begin),
		.qhead_count(qhead_count),
		.kvhead_begin(kvhead_begin),
		.kvhead_count(kvhead_count),
		.qrow_begin(qrow_begin),
		.qrow_count(qrow_count),
		.kvrow_begin(kvrow_begin),
		.kvrow_count(kvrow_count),
		.ffnrow_begin(ffnrow_begin),
		.ffnrow_count(ffnrow_count),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked),
		.full_plans(full_plans),
		.status_seen(status_seen)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(CLK_PERIOD * 200000);
		$display("** tensor_parallel_shard_planner: FAILED **");
		$finish;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// drop start and drain every outstanding plan
	task automatic settle();
		if (start)
			start <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic load_model(input logic [16:0] q, input logic [16:0] kv,
			input logic [16:0] hd, input logic [16:0] ffn, input logic [16:0] w,
			input logic [16:0] ot, input logic [16:0] dt);
		settle();
		write_reg(CFG_SPARE, 17'($urandom));
		write_reg(tpsp_pkg::CFG_QUERY_HEADS, q);
		write_reg(tpsp_pkg::CFG_KV_HEADS, kv);
		write_reg(tpsp_pkg::CFG_HEAD_DIMENSION, hd);
		write_reg(tpsp_pkg::CFG_FFN_SIZE, ffn);
		write_reg(tpsp_pkg::CFG_WORLD_SIZE, w);
		write_reg(tpsp_pkg::CFG_OUT_PROJ_TYPE, ot);
		write_reg(tpsp_pkg::CFG_DOWN_PROJ_TYPE, dt);
		cfg_valid <= 1'b0;
		cur_world = w[6:0];
		settings_used++;
	endtask

	task automatic send_rank(input logic [5:0] r);
		start <= 1'b1;
		rank_index <= r;
		do @(posedge clk); while (busy);
		items_sent++;
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
	endtask

	function automatic logic [5:0] pick_rank();
		if (cur_world >= 1 && cur_world <= tpsp_pkg::MAX_RANKS && $urandom_range(0, 9) < 8)
			return 6'($urandom_range(0, cur_world - 1));
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic logic [4:0] unknown_type();
		logic [4:0] id;
		do id = 5'($urandom_range(0, 31));
		while (id == tpsp_pkg::QT_F32 || id == tpsp_pkg::QT_F16 || id == tpsp_pkg::QT_Q8
			|| id == tpsp_pkg::QT_Q4K || id == tpsp_pkg::QT_Q6K);
		return id;
	endfunction

	// mostly consistent models, some with one flaw, a few pure noise
	task automatic random_model();
		logic [4:0]  type_ids [5];
		int unsigned type_lens [5];
		int unsigned w, kv, q, hd, ffn, ot, dt, db, blocks, k;
		type_ids = '{tpsp_pkg::QT_F32, tpsp_pkg::QT_F16, tpsp_pkg::QT_Q8,
			tpsp_pkg::QT_Q4K, tpsp_pkg::QT_Q6K};
		type_lens = '{1, 1, 32, 256, 256};
		if ($urandom_range(0, 9) == 0) begin
			load_model(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
				17'($urandom), 17'($urandom), 17'($urandom));
		end else begin
			w = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) :
				$urandom_range(1, tpsp_pkg::MAX_RANKS);
			kv = w * $urandom_range(1, (511 / w < 8) ? 511 / w : 8);
			q = kv * $urandom_range(1, 511 / kv);
			ot = type_ids[$urandom_range(0, 4)];
			case ($urandom_range(0, 2))
				0:       hd = $urandom_range(1, 1023);
				1:       hd = 32 * $urandom_range(1, 31);
				default: hd = 256 * $urandom_range(1, 3);
			endcase
			k = $urandom_range(0, 4);
			dt = type_ids[k];
			db = type_lens[k];
			blocks = ($urandom_range(0, 1) == 0) ? $urandom_range(w, w * 4) :
				$urandom_range(w, 131071 / db);
			ffn = blocks * db;
			if ($urandom_range(0, 9) < 3) begin
				case ($urandom_range(0, 8))
					0: w = ($urandom_range(0, 1) == 0) ? 0 :
						$urandom_range(tpsp_pkg::MAX_RANKS + 1, 127);
					1: begin
						case ($urandom_range(0, 3))
							0:       q = 0;
							1:       kv = 0;
							2:       hd = 0;
							default: ffn = 0;
						endcase
					end
					2: kv = (kv > 1) ? kv - 1 : kv;
					3: q = (q > 1) ? q - 1 : q;
					4: ot = unknown_type();
					5: begin
						ot = tpsp_pkg::QT_Q4K;
						hd = $urandom_range(1, 255);
					end
					6: dt = unknown_type();
					7: begin
						dt = tpsp_pkg::QT_Q6K;
						ffn = 256 * $urandom_range(1, 511) - $urandom_range(1, 255);
					end
					default: begin
						if (w > 1) begin
							dt = tpsp_pkg::QT_Q8;
							ffn = 32 * $urandom_range(1, w - 1);
						end
					end
				endcase
			end
			load_model(17'(q), 17'(kv), 17'(hd), 17'(ffn), 17'(w), 17'(ot), 17'(dt));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		rank_index = '0;
		items_sent = 0;
		settings_used = 0;
		burst_left = 4;
		cur_world = 1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_rank(6'd0);
		send_rank(6'd63);
		load_model(511, 511, 1023, 131071, 1, tpsp_pkg::QT_F32, tpsp_pkg::QT_F16);
		send_rank(6'd0);
		load_model(448, 64, 1023, 131071, 64, tpsp_pkg::QT_F16, tpsp_pkg::QT_F32);
		send_rank(6'd0);
		send_rank(6'd63);
		send_rank(6'd31);
		load_model(8, 8, 64, 1024, 0, tpsp_pkg::QT_F32, tpsp_pkg::QT_F32);
		send_rank(6'd0);
		load_model(64, 64, 64, 1024, 127, tpsp_pkg::QT_F32, tpsp_pkg::QT_F32);
		send_rank(6'd5);
		load_model(64, 64, 64, 1024, 65, tpsp_pkg::QT_F32, tpsp_pkg::QT_F32);
		send_rank(6'd0);
		load_model(0, 8, 64, 1024, 4, tpsp_pkg::QT_F32, tpsp_pkg::QT_F32);
		send_rank(6'd1);
		load_model(8, 0, 64, 1024, 4, tpsp_pkg::QT_F32, tpsp_pkg::QT_F32);
		send_rank(6'd1);
		load_model(8, 8, 0, 1024, 4, tpsp_pkg::QT_F32, tpsp_pkg::QT_F32);
		send_rank(6'd1);
		load_model(8, 8, 64, 0, 4, tpsp_pkg::QT_F32, tpsp_pkg::QT_F32);
		send_rank(6'd1);
		load_model(8, 3, 64, 1024, 2, tpsp_pkg::QT_F32, tpsp_pkg::QT_F32);
		send_rank(6'd1);
		load_model(3, 2, 64, 1024, 2, tpsp_pkg::QT_F32, tpsp_pkg::QT_F32);
		send_rank(6'd1);
		load_model(4, 2, 64, 1024, 2, 5'd2, tpsp_pkg::QT_F32);
		send_rank(6'd1);
		load_model(4, 2, 100, 1024, 2, tpsp_pkg::QT_Q4K, tpsp_pkg::QT_F32);
		send_rank(6'd1);
		load_model(4, 2, 256, 1024, 2, tpsp_pkg::QT_Q4K, 5'd31);
		send_rank(6'd1);
		load_model(4, 2, 256, 1000, 2, tpsp_pkg::QT_Q4K, tpsp_pkg::QT_Q6K);
		send_rank(6'd1);
		load_model(4, 4, 64, 96, 4, tpsp_pkg::QT_Q8, tpsp_pkg::QT_Q8);
		send_rank(6'd2);
		load_model(8, 4, 64, 224, 4, tpsp_pkg::QT_Q8, tpsp_pkg::QT_Q8);
		send_rank(6'd0);
		send_rank(6'd1);
		send_rank(6'd2);
		send_rank(6'd3);

		item_goal = items_sent + RANDOM_ITEMS;
		while (items_sent < item_goal) begin
			random_model();
			repeat ($urandom_range(10, 40)) send_rank(pick_rank());
		end

		settle();
		repeat (12) @(negedge clk);
		$display("planned %0d rank requests under %0d register settings, %0d full shard plans",
			checked, settings_used, full_plans);
		$display("status codes returned, one bit per code: %b", status_seen);
		if (mismatches == 0)
			$display("** tensor_parallel_shard_planner: PASSED **");
		else
			$display("** tensor_parallel_shard_planner: FAILED **");
		$finish;
	end

endmodule
